// ===== hdl/ort_pkg.sv =====
// Package for the ordered record table: sizes, record type, command and status codes.
package ort_pkg;

  localparam int unsigned Depth   = 32;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned RecW    = 32 + 64 + 8;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_LIST_FWD  = 3'd1,
    CMD_LIST_REV  = 3'd2,
    CMD_SORT_NAME = 3'd3,
    CMD_SORT_ID   = 3'd4,
    CMD_DELETE    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        head;
    logic [7:0]         tail;
  } rec_t;

  // Read port request and write port request of the record memory.
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    rec_t            wdata;
  } mem_req_t;

endpackage

// ===== hdl/ort_mem.sv =====
// Record memory: one write port, one registered read port.
module ort_mem (
  input  logic              clk_i,
  input  ort_pkg::mem_req_t req_i,
  output ort_pkg::rec_t     rdata_o
);
  import ort_pkg::*;

  rec_t mem_q [Depth];

  // Write, and read into a registered output
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

// ===== hdl/ordered_record_table.sv =====
// Top level of the ordered record table: command sequencer around the record memory.
// The block holds up to 32 records in one single-port-write, registered-read memory and
// works on one command at a time. Each memory read is issued in one state and its data
// is taken in a separate wait state. An insert or delete scans all n entries and then
// moves the m entries above the target. Listing reads one record at a time and waits
// while the output register is still full, and a sort is a bubble sort of n(n-1)/2
// compare steps, with an extra write step when the pair is swapped. Insert, delete and sort
// answer with one beat; listing answers with one beat per record, tlast on the final one.
// A new command is taken only after the previous one has delivered its final beat.
module ordered_record_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd[2:0], key_id[34:3], name_head[98:35], name_tail[106:99], zero pad to 112
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: rec_valid[0], rec_id[32:1], rec_name_head[96:33], rec_name_tail[104:97],
  //        status[106:105], zero pad to 112
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import ort_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_FIND   = 12'b000000000010, // issue read of scan entry
    S_FINDW  = 12'b000000000100, // check scan entry
    S_SHR    = 12'b000000001000, // read entry to move up
    S_SHRW   = 12'b000000010000, // write it one place higher
    S_DELR   = 12'b000000100000, // read entry to move down
    S_DELW   = 12'b000001000000,
    S_LISTR  = 12'b000010000000,
    S_LISTW  = 12'b000100000000,
    S_SORTA  = 12'b001000000000, // read j, or write j+1 of a pending swap
    S_SORTB  = 12'b010000000000, // read j+1, capture j
    S_SORTC  = 12'b100000000000  // compare, first swap write
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] pass_q, pass_d;
  logic            swp_q, swp_d; // second swap write pending
  cmd_e            cmd_q, cmd_d;
  rec_t            key_q, key_d;
  rec_t            a_q, a_d;
  logic            out_v_q, out_v_d;
  logic [111:0]    out_data_q, out_data_d;
  logic            out_last_q, out_last_d;
  logic            found_q, found_d;

  mem_req_t req;
  rec_t     rdata;

  ort_mem u_mem (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  function automatic logic [111:0] pack_out(logic v, rec_t r, status_e st);
    logic [111:0] d;
    d = '0;
    d[0]       = v;
    if (v) begin
      d[32:1]   = r.id;
      d[96:33]  = r.head;
      d[104:97] = r.tail;
    end
    d[106:105] = st;
    return d;
  endfunction

  logic gt;
  always_comb begin
    if (cmd_q == CMD_SORT_NAME) gt = {a_q.head, a_q.tail} > {rdata.head, rdata.tail};
    else                        gt = a_q.id > rdata.id;
  end

  // Sequence commands
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; pos_d = pos_q; pass_d = pass_q;
    swp_d = swp_q; cmd_d = cmd_q; key_d = key_q; a_d = a_q; found_d = found_q;
    out_v_d = out_v_q; out_data_d = out_data_q; out_last_d = out_last_q;
    req = '0;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d    = cmd_e'(s_axis_tdata[2:0]);
          key_d.id   = s_axis_tdata[34:3];
          key_d.head = s_axis_tdata[98:35];
          key_d.tail = s_axis_tdata[106:99];
          i_d = '0; pos_d = cnt_q; found_d = 1'b0; pass_d = CntW'(1); swp_d = 1'b0;
          unique case (s_axis_tdata[2:0])
            CMD_INSERT, CMD_DELETE: state_d = S_FIND;
            CMD_LIST_FWD, CMD_LIST_REV: begin
              if (cnt_q == '0) begin
                out_v_d = 1'b1; out_last_d = 1'b1;
                out_data_d = pack_out(1'b0, key_d, ST_DONE);
              end else state_d = S_LISTR;
            end
            CMD_SORT_NAME, CMD_SORT_ID: begin
              if (cnt_q > CntW'(1)) state_d = S_SORTA;
              else begin
                out_v_d = 1'b1; out_last_d = 1'b1;
                out_data_d = pack_out(1'b0, key_d, ST_DONE);
              end
            end
            default: begin
              out_v_d = 1'b1; out_last_d = 1'b1;
              out_data_d = pack_out(1'b0, key_d, ST_DONE);
            end
          endcase
        end
      end
      // Scan all entries: look for the key and the first larger id
      S_FIND: begin
        if (i_q == cnt_q) begin
          out_v_d = 1'b1; out_last_d = 1'b1; state_d = S_IDLE;
          if (cmd_q == CMD_DELETE) begin
            if (found_q) begin
              i_d = pos_q; state_d = S_DELR; out_v_d = 1'b0;
            end else out_data_d = pack_out(1'b0, key_q, ST_NOT_FOUND);
          end else if (found_q) begin
            out_data_d = pack_out(1'b0, key_q, ST_DUP);
          end else if (cnt_q == CntW'(Depth)) begin
            out_data_d = pack_out(1'b0, key_q, ST_FULL);
          end else begin
            out_v_d = 1'b0; i_d = cnt_q; state_d = S_SHR;
          end
        end else begin
          req.re = 1'b1; req.raddr = i_q[IdxW-1:0]; state_d = S_FINDW;
        end
      end
      S_FINDW: begin
        if (rdata.id == key_q.id) begin
          found_d = 1'b1;
          if (cmd_q == CMD_DELETE) pos_d = i_q;
        end
        if (cmd_q == CMD_INSERT && rdata.id > key_q.id && pos_q == cnt_q) pos_d = i_q;
        i_d = i_q + 1'b1; state_d = S_FIND;
      end
      // Move entries above pos up by one, then write the new record
      S_SHR: begin
        if (i_q == pos_q) begin
          req.we = 1'b1; req.waddr = pos_q[IdxW-1:0]; req.wdata = key_q;
          cnt_d = cnt_q + 1'b1; state_d = S_IDLE;
          out_v_d = 1'b1; out_last_d = 1'b1; out_data_d = pack_out(1'b0, key_q, ST_DONE);
        end else begin
          req.re = 1'b1; req.raddr = IdxW'(i_q - 1'b1); state_d = S_SHRW;
        end
      end
      S_SHRW: begin
        req.we = 1'b1; req.waddr = i_q[IdxW-1:0]; req.wdata = rdata;
        i_d = i_q - 1'b1; state_d = S_SHR;
      end
      // Move entries above the deleted one down by one
      S_DELR: begin
        if (i_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1; state_d = S_IDLE;
          out_v_d = 1'b1; out_last_d = 1'b1; out_data_d = pack_out(1'b0, key_q, ST_DONE);
        end else begin
          req.re = 1'b1; req.raddr = IdxW'(i_q + 1'b1); state_d = S_DELW;
        end
      end
      S_DELW: begin
        req.we = 1'b1; req.waddr = i_q[IdxW-1:0]; req.wdata = rdata;
        i_d = i_q + 1'b1; state_d = S_DELR;
      end
      // Emit one beat per record once the output register is free
      S_LISTR: begin
        if (!out_v_q) begin
          req.re = 1'b1;
          req.raddr = (cmd_q == CMD_LIST_FWD) ? i_q[IdxW-1:0]
                                              : IdxW'(cnt_q - 1'b1 - i_q);
          state_d = S_LISTW;
        end
      end
      S_LISTW: begin
        out_v_d = 1'b1; out_last_d = (i_q + 1'b1 == cnt_q);
        out_data_d = pack_out(1'b1, rdata, ST_DONE);
        i_d = i_q + 1'b1;
        state_d = (i_q + 1'b1 == cnt_q) ? S_IDLE : S_LISTR;
      end
      // Bubble sort: compare j and j+1, swap when out of order
      S_SORTA: begin
        if (swp_q) begin
          req.we = 1'b1; req.waddr = IdxW'(i_q + 1'b1); req.wdata = a_q;
          swp_d = 1'b0;
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 + pass_q >= cnt_q) begin
            i_d = '0; pass_d = pass_q + 1'b1;
            if (pass_q + 1'b1 >= cnt_q) begin
              state_d = S_IDLE; out_v_d = 1'b1; out_last_d = 1'b1;
              out_data_d = pack_out(1'b0, key_q, ST_DONE);
            end
          end
        end else begin
          req.re = 1'b1; req.raddr = i_q[IdxW-1:0]; state_d = S_SORTB;
        end
      end
      S_SORTB: begin
        a_d = rdata;
        req.re = 1'b1; req.raddr = IdxW'(i_q + 1'b1); state_d = S_SORTC;
      end
      S_SORTC: begin
        state_d = S_SORTA;
        if (gt) begin
          req.we = 1'b1; req.waddr = i_q[IdxW-1:0]; req.wdata = rdata; swp_d = 1'b1;
        end else begin
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 + pass_q >= cnt_q) begin
            i_d = '0; pass_d = pass_q + 1'b1;
            if (pass_q + 1'b1 >= cnt_q) begin
              state_d = S_IDLE; out_v_d = 1'b1; out_last_d = 1'b1;
              out_data_d = pack_out(1'b0, key_q, ST_DONE);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; out_v_q <= 1'b0; swp_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; out_v_q <= out_v_d; swp_q <= swp_d;
    end
  end

  // Hold working registers
  always_ff @(posedge clk_i) begin
    i_q <= i_d; pos_q <= pos_d; pass_q <= pass_d; cmd_q <= cmd_d; key_q <= key_d;
    a_q <= a_d; found_q <= found_d; out_data_q <= out_data_d; out_last_q <= out_last_d;
  end

endmodule
